FILE: rtl/ir_code_unpacker_macros.svh
// Assertion macros for the IR code unpacker checker.
`ifndef IR_CODE_UNPACKER_MACROS_SVH
`define IR_CODE_UNPACKER_MACROS_SVH

// Same-cycle implication, clocked on clk, disabled in reset.
`define IRCU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, disabled in reset.
`define IRCU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ircu_pkg.sv
// Shared types and constants of the IR code unpacker.
package ircu_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int TBL_IDX_W     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int TBL_CMP_W     = 5;
    localparam int INDEX_W       = 4;
    localparam int WORD_W        = 16;
    localparam int BYTE_W        = 8;
    localparam int BIT_POS_W     = 3;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [WORD_W-1:0] START_BASE = 16'hFF00;
    localparam logic [WORD_W-1:0] OFF_CLAMP  = 16'hFEFF;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_BYTE  = 2'd2;

    typedef struct packed {
        logic              is_start;
        logic [WORD_W-1:0] word0;
        logic [WORD_W-1:0] off_word;
        logic              truncated;
        logic              term;
        logic              last;
    } ircu_entry_t;

    typedef struct packed {
        logic        valid;
        ircu_entry_t entry;
    } ircu_push_t;

    typedef struct packed {
        logic        valid;
        ircu_entry_t entry;
    } ircu_head_t;

endpackage

FILE: rtl/ircu_if.sv
// Request and result channel interfaces of the IR code unpacker.
interface ircu_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [3:0]  table_index;
    logic [15:0] on_time;
    logic [15:0] off_time;
    logic [7:0]  timer_value;
    logic [7:0]  code_byte;

    modport source (
        output valid, cmd, table_index, on_time, off_time, timer_value, code_byte,
        input  ready
    );
    modport sink (
        input  valid, cmd, table_index, on_time, off_time, timer_value, code_byte,
        output ready
    );
endinterface

interface ircu_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] word;
    logic        is_start;
    logic        truncated;
    logic        code_end;
    logic        last;

    modport source (
        output valid, word, is_start, truncated, code_end, last,
        input  ready
    );
    modport sink (
        input  valid, word, is_start, truncated, code_end, last,
        output ready
    );
endinterface

FILE: rtl/ircu_front.sv
// Front end: accepts requests, holds the time table and walks code bits.
module ircu_front
    import ircu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    ircu_in_if.sink    req,
    input  logic       q_full,
    output ircu_push_t push
);

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_HEADER = 4'b0010,
        PH_INDEX  = 4'b0100,
        PH_DONE   = 4'b1000
    } ircu_phase_t;

    typedef struct packed {
        logic [WORD_W-1:0] on_t;
        logic [WORD_W-1:0] off_t;
    } tbl_entry_t;

    tbl_entry_t tbl_reg [TABLE_ENTRIES];

    ircu_phase_t          phase_reg, phase_next;
    logic [1:0]           type_reg, type_next;
    logic [2:0]           hdr_bits_reg, hdr_bits_next;
    logic [INDEX_W-1:0]   idx_acc_reg, idx_acc_next;
    logic [2:0]           idx_bits_reg, idx_bits_next;
    logic                 busy_reg, busy_next;
    logic [BYTE_W-1:0]    byte_reg, byte_next;
    logic [BIT_POS_W-1:0] bit_pos_reg, bit_pos_next;

    logic acc;
    logic load_hit;

    assign req.ready = !busy_reg && !q_full;
    assign acc       = req.valid && req.ready;
    assign load_hit  = ({1'b0, req.table_index} < TBL_CMP_W'(TABLE_ENTRIES));

    always_comb
    begin
        logic               bit_val;
        ircu_phase_t        ph_c;
        logic [1:0]         ty_c;
        logic [2:0]         hb_c;
        logic [INDEX_W-1:0] ia_c;
        logic [2:0]         ib_c;
        logic [2:0]         need;
        logic               complete;
        logic               hit;
        logic [WORD_W-1:0]  on_v;
        logic [WORD_W-1:0]  off_v;

        phase_next    = phase_reg;
        type_next     = type_reg;
        hdr_bits_next = hdr_bits_reg;
        idx_acc_next  = idx_acc_reg;
        idx_bits_next = idx_bits_reg;
        busy_next     = busy_reg;
        byte_next     = byte_reg;
        bit_pos_next  = bit_pos_reg;
        push          = '0;

        bit_val  = byte_reg[bit_pos_reg];
        ph_c     = phase_reg;
        ty_c     = type_reg;
        hb_c     = hdr_bits_reg;
        ia_c     = idx_acc_reg;
        ib_c     = idx_bits_reg;
        need     = 3'd4 - {1'b0, type_reg};
        complete = 1'b0;
        hit      = 1'b0;
        on_v     = '0;
        off_v    = '0;

        if (busy_reg)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (hdr_bits_reg < 3'd2)
                    begin
                        ty_c = {type_reg[0], bit_val};
                    end
                    hb_c = hdr_bits_reg + 3'd1;
                    if ((hb_c == 3'd2 && ty_c != 2'd0) || hb_c >= 3'd4)
                    begin
                        ph_c = PH_INDEX;
                        ia_c = '0;
                        ib_c = '0;
                    end
                end
                PH_INDEX:
                begin
                    ia_c = {idx_acc_reg[INDEX_W-2:0], bit_val};
                    ib_c = idx_bits_reg + 3'd1;
                    if (ib_c >= need)
                    begin
                        complete = 1'b1;
                        hit = ({1'b0, ia_c} < TBL_CMP_W'(TABLE_ENTRIES));
                        if (hit)
                        begin
                            on_v  = tbl_reg[ia_c[TBL_IDX_W-1:0]].on_t;
                            off_v = tbl_reg[ia_c[TBL_IDX_W-1:0]].off_t;
                        end
                        ia_c = '0;
                        ib_c = '0;
                        if (off_v == '0)
                        begin
                            ph_c = PH_DONE;
                        end
                    end
                end
                default:
                begin
                    ph_c = phase_reg;
                end
            endcase

            if (!(complete && q_full))
            begin
                phase_next    = ph_c;
                type_next     = ty_c;
                hdr_bits_next = hb_c;
                idx_acc_next  = ia_c;
                idx_bits_next = ib_c;
                if (bit_pos_reg == '0 || (ph_c != PH_HEADER && ph_c != PH_INDEX))
                begin
                    busy_next = 1'b0;
                end
                else
                begin
                    bit_pos_next = bit_pos_reg - BIT_POS_W'(1);
                end
                if (complete)
                begin
                    push.valid          = 1'b1;
                    push.entry.is_start = 1'b0;
                    push.entry.word0    = on_v;
                    push.entry.term     = (off_v == '0);
                    push.entry.truncated = (off_v >= START_BASE);
                    push.entry.off_word = (off_v >= START_BASE) ? OFF_CLAMP : off_v;
                    push.entry.last     = (off_v == '0) || (bit_pos_reg < need);
                end
            end
        end
        else if (acc)
        begin
            unique case (req.cmd)
                CMD_START:
                begin
                    phase_next          = PH_HEADER;
                    type_next           = '0;
                    hdr_bits_next       = '0;
                    idx_acc_next        = '0;
                    idx_bits_next       = '0;
                    push.valid          = 1'b1;
                    push.entry.is_start = 1'b1;
                    push.entry.word0    = START_BASE + WORD_W'(req.timer_value);
                    push.entry.off_word = '0;
                    push.entry.truncated = 1'b0;
                    push.entry.term     = 1'b0;
                    push.entry.last     = 1'b1;
                end
                CMD_BYTE:
                begin
                    if (phase_reg == PH_HEADER || phase_reg == PH_INDEX)
                    begin
                        busy_next    = 1'b1;
                        byte_next    = req.code_byte;
                        bit_pos_next = BIT_POS_W'(BYTE_W - 1);
                    end
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc && req.cmd == CMD_LOAD && load_hit)
        begin
            tbl_reg[req.table_index[TBL_IDX_W-1:0]].on_t  <= req.on_time;
            tbl_reg[req.table_index[TBL_IDX_W-1:0]].off_t <= req.off_time;
        end
        byte_reg <= byte_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            type_reg     <= '0;
            hdr_bits_reg <= '0;
            idx_acc_reg  <= '0;
            idx_bits_reg <= '0;
            busy_reg     <= 1'b0;
            bit_pos_reg  <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            type_reg     <= type_next;
            hdr_bits_reg <= hdr_bits_next;
            idx_acc_reg  <= idx_acc_next;
            idx_bits_reg <= idx_bits_next;
            busy_reg     <= busy_next;
            bit_pos_reg  <= bit_pos_next;
        end
    end

endmodule

FILE: rtl/ircu_queue.sv
// Short queue of pending output operations between front and back.
module ircu_queue
    import ircu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  ircu_push_t push,
    output logic       full,
    input  logic       pop,
    output ircu_head_t head
);

    ircu_entry_t mem_reg [QUEUE_DEPTH];

    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;

    logic do_push;
    logic do_pop;

    assign full       = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.entry = mem_reg[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                          wr_ptr_reg + QUEUE_PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                          rd_ptr_reg + QUEUE_PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QUEUE_CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/ircu_back.sv
// Back end: expands queued operations into output words through an output register.
module ircu_back
    import ircu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  ircu_head_t head,
    output logic       pop,
    ircu_out_if.source res
);

    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic              is_start_reg, is_start_next;
    logic              trunc_reg, trunc_next;
    logic              end_reg, end_next;
    logic              last_reg, last_next;

    logic              pend_reg, pend_next;
    logic [WORD_W-1:0] pend_word_reg, pend_word_next;
    logic              pend_trunc_reg, pend_trunc_next;
    logic              pend_last_reg, pend_last_next;

    logic out_free;

    assign res.valid     = out_valid_reg;
    assign res.word      = word_reg;
    assign res.is_start  = is_start_reg;
    assign res.truncated = trunc_reg;
    assign res.code_end  = end_reg;
    assign res.last      = last_reg;
    assign out_free      = !out_valid_reg || res.ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        word_next       = word_reg;
        is_start_next   = is_start_reg;
        trunc_next      = trunc_reg;
        end_next        = end_reg;
        last_next       = last_reg;
        pend_next       = pend_reg;
        pend_word_next  = pend_word_reg;
        pend_trunc_next = pend_trunc_reg;
        pend_last_next  = pend_last_reg;
        pop             = 1'b0;

        if (out_free)
        begin
            priority if (pend_reg)
            begin
                out_valid_next = 1'b1;
                word_next      = pend_word_reg;
                is_start_next  = 1'b0;
                trunc_next     = pend_trunc_reg;
                end_next       = 1'b0;
                last_next      = pend_last_reg;
                pend_next      = 1'b0;
            end
            else if (head.valid)
            begin
                pop             = 1'b1;
                out_valid_next  = 1'b1;
                word_next       = head.entry.word0;
                is_start_next   = head.entry.is_start;
                trunc_next      = 1'b0;
                end_next        = head.entry.term;
                last_next       = (head.entry.is_start || head.entry.term) ?
                                  head.entry.last : 1'b0;
                pend_next       = !head.entry.is_start && !head.entry.term;
                pend_word_next  = head.entry.off_word;
                pend_trunc_next = head.entry.truncated;
                pend_last_next  = head.entry.last;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg       <= word_next;
        is_start_reg   <= is_start_next;
        trunc_reg      <= trunc_next;
        end_reg        <= end_next;
        last_reg       <= last_next;
        pend_word_reg  <= pend_word_next;
        pend_trunc_reg <= pend_trunc_next;
        pend_last_reg  <= pend_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

endmodule

FILE: rtl/ir_code_unpacker.sv
// Top level of the IR code unpacker: front end, queue and back end.
//
// req carries one request per valid/ready handshake: a table load, a start
// command or one packed code byte. res carries the expanded 16-bit words,
// one per handshake, with last marking the final word caused by a request.
// A load is absorbed and gives no word. A start's word passes through the
// queue and then the single-word output register. A code byte is walked
// one bit per cycle while the queue has space, so the front end is busy for
// the byte, finishing early once the code ends and holding while the queue
// is full; each completed index is queued and leaves the back end as an on
// word then an off word, or an on word alone where its off time is zero. A
// byte of eight 1-bit indices therefore gives sixteen output words.
// A four-entry queue separates the bit walker from the output register; when
// the receiver stalls, the output holds, the queue fills, and the front end
// drops ready until space frees. Reset clears the queue, the output and the
// unpacking state to idle; the time table holds no reset value and must be
// loaded before use.
module ir_code_unpacker
    import ircu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    ircu_in_if.sink    req,
    ircu_out_if.source res
);

    ircu_push_t push;
    ircu_head_t head;
    logic       q_full;
    logic       pop;

    ircu_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .q_full (q_full),
        .push   (push)
    );

    ircu_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (q_full),
        .pop   (pop),
        .head  (head)
    );

    ircu_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .res   (res)
    );

endmodule

FILE: rtl/ircu_checker.sv
// Port-level checker of the IR code unpacker and its bind.
`include "ir_code_unpacker_macros.svh"

module ircu_checker
    import ircu_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              res_valid,
    input logic              res_ready,
    input logic [WORD_W-1:0] res_word,
    input logic              res_is_start,
    input logic              res_truncated,
    input logic              res_code_end,
    input logic              res_last
);

    `IRCU_ASSERT_NXT(a_res_hold, res_valid && !res_ready,
                     res_valid && $stable(res_word) && $stable(res_last),
                     "stalled result changed")
    `IRCU_ASSERT_IMP(a_start_alone, res_valid && res_is_start,
                     res_last && !res_truncated && !res_code_end,
                     "start word not a lone last result")
    `IRCU_ASSERT_IMP(a_trunc_word, res_valid && res_truncated,
                     res_word == OFF_CLAMP && !res_is_start && !res_code_end,
                     "truncated word is not the clamp value")
    `IRCU_ASSERT_IMP(a_end_last, res_valid && res_code_end, res_last, "code end not marked last")

endmodule

bind ir_code_unpacker ircu_checker u_ircu_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .res_word      (res.word),
    .res_is_start  (res.is_start),
    .res_truncated (res.truncated),
    .res_code_end  (res.code_end),
    .res_last      (res.last)
);

FILE: tb/tb.sv
// Testbench for the IR code unpacker: queued requests, predicted words, checked results.
`timescale 1ns / 1ps

module tb
    import ircu_pkg::*;
();

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 900_000;
    localparam int TAIL_CYCLES = 40;
    localparam int CALM_TAIL   = 50;
    localparam int ITEM_TARGET = 480;
    localparam int ERROR_PRINT = 50;

    typedef enum logic [1:0] {PH_IDLE, PH_HEADER, PH_INDEX, PH_DONE} unpack_phase_t;

    typedef struct {
        logic [1:0]  cmd;
        logic [3:0]  table_index;
        logic [15:0] on_time;
        logic [15:0] off_time;
        logic [7:0]  timer_value;
        logic [7:0]  code_byte;
        bit          drain_first;
    } ir_request_t;

    typedef struct packed {
        logic [15:0] word;
        logic        is_start;
        logic        truncated;
        logic        code_end;
        logic        last;
    } ir_word_t;

    logic clk;
    logic rst_n;

    ircu_in_if  req_ch ();
    ircu_out_if res_ch ();

    ir_code_unpacker dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .res   (res_ch.source)
    );

    // predictor state
    logic [15:0]   on_tbl [TABLE_ENTRIES];
    logic [15:0]   off_tbl [TABLE_ENTRIES];
    unpack_phase_t ph;
    logic [1:0]    code_type;
    logic [2:0]    hdr_seen;
    logic [3:0]    idx_acc;
    logic [2:0]    idx_seen;

    ir_request_t pending_reqs [$];
    ir_word_t    expected_words [$];
    ir_request_t cur_req;
    bit          req_taken;
    int          errors;
    int          cycles;
    int          req_gap;
    int          req_free;
    int          res_gap;
    int          res_free;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void expand_request(input ir_request_t r);
        ir_word_t    words [$];
        ir_word_t    w;
        logic [15:0] on_w;
        logic [15:0] off_w;
        logic        bit_v;
        int          b;
        case (r.cmd)
            CMD_LOAD:
            begin
                if (int'(r.table_index) < TABLE_ENTRIES)
                begin
                    on_tbl[r.table_index]  = r.on_time;
                    off_tbl[r.table_index] = r.off_time;
                end
            end
            CMD_START:
            begin
                ph        = PH_HEADER;
                code_type = '0;
                hdr_seen  = '0;
                idx_acc   = '0;
                idx_seen  = '0;
                words.push_back('{START_BASE + 16'(r.timer_value), 1'b1, 1'b0, 1'b0, 1'b0});
            end
            CMD_BYTE:
            begin
                for (b = 7; b >= 0; b--)
                begin
                    bit_v = r.code_byte[b];
                    if (ph == PH_HEADER)
                    begin
                        if (hdr_seen < 3'd2)
                            code_type = {code_type[0], bit_v};
                        hdr_seen++;
                        if ((hdr_seen == 3'd2 && code_type != 2'd0) || hdr_seen >= 3'd4)
                        begin
                            ph       = PH_INDEX;
                            idx_acc  = '0;
                            idx_seen = '0;
                        end
                    end
                    else if (ph == PH_INDEX)
                    begin
                        idx_acc = {idx_acc[2:0], bit_v};
                        idx_seen++;
                        if (int'(idx_seen) >= 4 - int'(code_type))
                        begin
                            on_w  = '0;
                            off_w = '0;
                            if (int'(idx_acc) < TABLE_ENTRIES)
                            begin
                                on_w  = on_tbl[idx_acc];
                                off_w = off_tbl[idx_acc];
                            end
                            idx_acc  = '0;
                            idx_seen = '0;
                            if (off_w == 16'd0)
                            begin
                                words.push_back('{on_w, 1'b0, 1'b0, 1'b1, 1'b0});
                                ph = PH_DONE;
                            end
                            else
                            begin
                                words.push_back('{on_w, 1'b0, 1'b0, 1'b0, 1'b0});
                                if (off_w >= START_BASE)
                                    words.push_back('{OFF_CLAMP, 1'b0, 1'b1, 1'b0, 1'b0});
                                else
                                    words.push_back('{off_w, 1'b0, 1'b0, 1'b0, 1'b0});
                            end
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (words.size() > 0)
        begin
            w = words.pop_back();
            w.last = 1'b1;
            words.push_back(w);
        end
        foreach (words[i])
            expected_words.push_back(words[i]);
    endfunction

    function automatic ir_request_t random_request();
        ir_request_t r;
        r.cmd         = 2'($urandom_range(0, 3));
        r.table_index = 4'($urandom_range(0, 15));
        r.on_time     = 16'($urandom);
        r.off_time    = 16'($urandom);
        r.timer_value = 8'($urandom);
        r.code_byte   = 8'($urandom);
        r.drain_first = 1'b0;
        return r;
    endfunction

    function automatic logic [15:0] pick_off_time();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return START_BASE + 16'($urandom_range(0, 255));
            2:       return 16'($urandom_range(16'hFE00, 16'hFEFF));
            default: return 16'($urandom_range(1, 16'hFEFF));
        endcase
    endfunction

    task automatic add_load(input logic [3:0] idx, input logic [15:0] on_v,
                            input logic [15:0] off_v);
        ir_request_t r;
        r             = random_request();
        r.cmd         = CMD_LOAD;
        r.table_index = idx;
        r.on_time     = on_v;
        r.off_time    = off_v;
        pending_reqs.push_back(r);
    endtask

    task automatic add_start(input logic [7:0] timer, input bit drain);
        ir_request_t r;
        r             = random_request();
        r.cmd         = CMD_START;
        r.timer_value = timer;
        r.drain_first = drain;
        pending_reqs.push_back(r);
    endtask

    task automatic add_byte(input logic [7:0] code);
        ir_request_t r;
        r           = random_request();
        r.cmd       = CMD_BYTE;
        r.code_byte = code;
        pending_reqs.push_back(r);
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (rst_n && !(req_ch.valid && !req_taken))
        begin
            if (req_gap > 0)
            begin
                req_gap--;
                req_ch.valid <= 1'b0;
            end
            else if (pending_reqs.size() == 0 ||
                     (pending_reqs[0].drain_first && expected_words.size() != 0))
                req_ch.valid <= 1'b0;
            else if (pending_reqs.size() >= CALM_TAIL && req_free == 0 &&
                     $urandom_range(0, 5) == 0)
            begin
                req_gap = $urandom_range(0, 15);
                req_ch.valid <= 1'b0;
            end
            else
            begin
                cur_req = pending_reqs.pop_front();
                req_ch.cmd         <= cur_req.cmd;
                req_ch.table_index <= cur_req.table_index;
                req_ch.on_time     <= cur_req.on_time;
                req_ch.off_time    <= cur_req.off_time;
                req_ch.timer_value <= cur_req.timer_value;
                req_ch.code_byte   <= cur_req.code_byte;
                req_ch.valid       <= 1'b1;
                if (req_free > 0)
                    req_free--;
                else if ($urandom_range(0, 15) == 0)
                    req_free = $urandom_range(10, 60);
            end
        end
        req_taken = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            expand_request(cur_req);
            req_taken = 1'b1;
        end
    end

    // result receiver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (res_gap > 0)
            begin
                res_gap--;
                res_ch.ready <= 1'b0;
            end
            else if (pending_reqs.size() >= CALM_TAIL && res_free == 0 &&
                     $urandom_range(0, 4) == 0)
            begin
                res_gap = $urandom_range(0, 15);
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                if (res_free > 0)
                    res_free--;
                else if ($urandom_range(0, 19) == 0)
                    res_free = $urandom_range(10, 80);
            end
        end
    end

    always @(posedge clk)
    begin
        ir_word_t got;
        ir_word_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got = '{res_ch.word, res_ch.is_start, res_ch.truncated, res_ch.code_end,
                    res_ch.last};
            if (expected_words.size() == 0)
            begin
                if (errors < ERROR_PRINT)
                    $display("%0t: unexpected result, expected none,", $time,
                             " actual word=%h st=%b tr=%b end=%b last=%b",
                             got.word, got.is_start, got.truncated, got.code_end,
                             got.last);
                errors++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (got.word !== want.word || got.is_start !== want.is_start ||
                    got.truncated !== want.truncated || got.code_end !== want.code_end ||
                    got.last !== want.last)
                begin
                    if (errors < ERROR_PRINT)
                        $display("%0t: mismatch, expected word=%h st=%b tr=%b end=%b last=%b,",
                                 $time, want.word, want.is_start, want.truncated,
                                 want.code_end, want.last,
                                 " actual word=%h st=%b tr=%b end=%b last=%b",
                                 got.word, got.is_start, got.truncated, got.code_end,
                                 got.last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL ir_code_unpacker");
            $finish;
        end
    end

    initial
    begin
        int queued;
        int i;
        int n;
        int sel;
        ir_request_t r;

        clk                = 1'b0;
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.cmd         = CMD_LOAD;
        req_ch.table_index = '0;
        req_ch.on_time     = '0;
        req_ch.off_time    = '0;
        req_ch.timer_value = '0;
        req_ch.code_byte   = '0;
        res_ch.ready       = 1'b0;
        req_taken          = 1'b0;
        errors             = 0;
        cycles             = 0;
        req_gap            = 0;
        req_free           = 0;
        res_gap            = 0;
        res_free           = 0;
        ph                 = PH_IDLE;
        code_type          = '0;
        hdr_seen           = '0;
        idx_acc            = '0;
        idx_seen           = '0;

        // directed: idle byte, unused command, full table, then hand-built codes
        add_byte(8'h5A);
        r = random_request();
        r.cmd = CMD_UNUSED;
        pending_reqs.push_back(r);
        add_load(4'd0, 16'h0000, 16'h0001);
        add_load(4'd1, 16'hFFFF, 16'hFEFF);
        add_load(4'd2, 16'h1234, 16'hFF00);
        add_load(4'd3, 16'hAAAA, 16'hFFFF);
        for (i = 4; i < 15; i++)
            add_load(4'(i), 16'($urandom), 16'($urandom_range(1, 16'hFEFF)));
        add_load(4'd15, 16'h5555, 16'h0000);
        add_start(8'h00, 1'b1);
        add_byte(8'hD6);
        add_byte(8'hFF);
        add_start(8'hFF, 1'b0);
        add_byte(8'h00);
        add_byte(8'hF3);
        add_byte(8'hAB);
        add_start(8'($urandom), 1'b0);
        add_byte(8'h58);
        add_byte(8'h2B);
        add_byte(8'hC5);
        queued = pending_reqs.size() - 2;

        // random: mostly start plus a run of code bytes, some reloads and noise
        while (queued < ITEM_TARGET)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 8)
            begin
                add_load(4'($urandom_range(0, 15)), 16'($urandom), pick_off_time());
                queued++;
            end
            else if (sel < 12)
            begin
                r = random_request();
                if ($urandom_range(0, 1) == 0)
                    r.cmd = CMD_UNUSED;
                pending_reqs.push_back(r);
            end
            else
            begin
                add_start(8'($urandom), $urandom_range(0, 39) == 0);
                queued++;
                n = $urandom_range(1, 6);
                for (i = 0; i < n; i++)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        add_load(4'($urandom_range(0, 15)), 16'($urandom), pick_off_time());
                        queued++;
                    end
                    add_byte(8'($urandom));
                    queued++;
                end
            end
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_reqs.size() != 0 || req_ch.valid || expected_words.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0 && expected_words.size() == 0)
            $display("PASS ir_code_unpacker");
        else
            $display("FAIL ir_code_unpacker");
        $finish;
    end

endmodule
